// ----- design/shdr_pkg.sv -----
// Package for the SHiP / DRRIP replacement engine: sizes, codes, payload widths,
// the per-row update result type and the fixed leader-set map.
// No dependencies; the other files that use it refer to it by scoped names.
`default_nettype none

package shdr_pkg;

    // Sizes. SETS and LEADER_SETS are powers of two.
    localparam int SETS          = 2048;
    localparam int WAYS          = 16;
    localparam int SIG_BITS      = 6;
    localparam int SELECTOR_BITS = 10;
    localparam int LEADER_SETS   = 64;

    localparam int SET_BITS     = $clog2(SETS);
    localparam int WAY_BITS     = $clog2(WAYS);
    localparam int SIG_COUNT    = 1 << SIG_BITS;
    localparam int RRPV_BITS    = 2;
    localparam int CNT_BITS     = 2;
    localparam int RR_ROW_BITS  = WAYS * RRPV_BITS;
    localparam int SIG_ROW_BITS = WAYS * SIG_BITS;
    localparam int CLEAR_LEN    = (SETS > SIG_COUNT) ? SETS : SIG_COUNT;
    localparam int CLEAR_BITS   = $clog2(CLEAR_LEN);
    localparam int LFSR_BITS    = 16;

    // Widths of the channel fields.
    localparam int KIND_W      = 1;
    localparam int SET_IDX_W   = 11;
    localparam int WAY_IDX_W   = 4;
    localparam int PC_W        = 6;
    localparam int LINE_W      = 6;
    localparam int HIT_W       = 1;
    localparam int VICTIM_W    = 4;
    localparam int INSERTED_W  = 2;
    localparam int SEL_OUT_W   = 10;

    // Request kinds and access outcomes.
    localparam logic [KIND_W-1:0] KIND_FIND   = 1'b0;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 1'b1;
    localparam logic [HIT_W-1:0]  ACC_FILL    = 1'b0;
    localparam logic [HIT_W-1:0]  ACC_HIT     = 1'b1;

    localparam logic [SELECTOR_BITS-1:0] SEL_MID = {1'b1, {(SELECTOR_BITS-1){1'b0}}};
    localparam logic [SELECTOR_BITS-1:0] SEL_MAX = '1;
    localparam logic [LFSR_BITS-1:0]     LFSR_SEED = 16'hACE1;

    localparam logic [RRPV_BITS-1:0] RRPV_NEAR    = 2'd0;
    localparam logic [RRPV_BITS-1:0] RRPV_LONG    = 2'd2;
    localparam logic [RRPV_BITS-1:0] RRPV_DISTANT = 2'd3;

    localparam logic [CNT_BITS-1:0] CNT_MAX    = 2'd3;
    localparam logic [CNT_BITS-1:0] CNT_STRONG = 2'd2;

    localparam int LEADER_STRIDE      = (SETS >= LEADER_SETS) ? SETS / LEADER_SETS : 1;
    localparam int LEADER_STRIDE_BITS = $clog2(LEADER_STRIDE);

    typedef enum logic [1:0] {
        ROLE_SRRIP,
        ROLE_BIMODAL,
        ROLE_FOLLOW
    } role_t;

    typedef enum logic [1:0] {
        UPD_FIND,
        UPD_HIT,
        UPD_FILL,
        UPD_NOP
    } upd_op_t;

    typedef struct packed {
        logic [WAY_BITS-1:0]     victim;
        logic [RR_ROW_BITS-1:0]  rr_row;
        logic [SIG_ROW_BITS-1:0] sig_row;
        logic [SIG_BITS-1:0]     old_sig;
    } row_upd_t;

    // Leader i sits at set i*SETS/LEADER_SETS; even i is an SRRIP leader, odd
    // i a bimodal one. When there are more leaders than sets, every set is hit
    // by several leaders and the last of them (always odd) wins.
    function automatic role_t set_role(input logic [SET_BITS-1:0] s);
        logic [SET_BITS-1:0] low_mask;
        logic [SET_BITS-1:0] leader_num;
        role_t               role;
        low_mask   = SET_BITS'(LEADER_STRIDE - 1);
        leader_num = s >> LEADER_STRIDE_BITS;
        if (SETS < LEADER_SETS) begin
            role = ROLE_BIMODAL;
        end
        else if ((s & low_mask) == '0) begin
            role = leader_num[0] ? ROLE_BIMODAL : ROLE_SRRIP;
        end
        else begin
            role = ROLE_FOLLOW;
        end
        return role;
    endfunction

endpackage

`default_nettype wire

// ----- design/shdr_if.sv -----
// Valid/ready channel interfaces for the request and the result words.
// Field widths come from shdr_pkg.
`default_nettype none

interface shdr_in_if;
    logic                           valid;
    logic                           ready;
    logic [shdr_pkg::KIND_W-1:0]    kind;
    logic [shdr_pkg::SET_IDX_W-1:0] set_index;
    logic [shdr_pkg::WAY_IDX_W-1:0] way_index;
    logic [shdr_pkg::PC_W-1:0]      pc_bits;
    logic [shdr_pkg::LINE_W-1:0]    line_bits;
    logic [shdr_pkg::HIT_W-1:0]     is_hit;

    modport source (
        output valid, kind, set_index, way_index, pc_bits, line_bits, is_hit,
        input  ready
    );
    modport sink (
        input  valid, kind, set_index, way_index, pc_bits, line_bits, is_hit,
        output ready
    );
endinterface

interface shdr_out_if;
    logic                            valid;
    logic                            ready;
    logic [shdr_pkg::VICTIM_W-1:0]   victim_way;
    logic [shdr_pkg::INSERTED_W-1:0] inserted_value;
    logic [shdr_pkg::SEL_OUT_W-1:0]  selector_value;

    modport source (
        output valid, victim_way, inserted_value, selector_value,
        input  ready
    );
    modport sink (
        input  valid, victim_way, inserted_value, selector_value,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/ship_drrip_cache_replacement_top.sv -----
// Top level of the SHiP / DRRIP replacement engine: sequencer, selector, LFSR,
// and the three memories. Uses shdr_pkg, shdr_if, shdr_ram and shdr_row_update.
`default_nettype none

//  channel  | dir | modport           | fields
//  ---------+-----+-------------------+----------------------------------------------
//  item     | in  | shdr_in_if.sink   | kind, set_index, way_index, pc_bits,
//           |     |                   | line_bits, is_hit
//  result   | out | shdr_out_if.source| victim_way, inserted_value, selector_value
//
// One word is in flight at a time. A find, a hit or an ignored update goes through
// a row read, then modify and write back; a fill takes a further step, because the
// replaced block's signature comes out of the row read and then addresses the
// reuse-counter memory for its decrement. After reset a clearing pass over
// max(SETS, SIG_COUNT) addresses writes every row and counter while item.ready
// stays low. A stalled result holds the sequencer in its last step.

module ship_drrip_cache_replacement_top (
    input  wire logic clk,
    input  wire logic rst_n,
    shdr_in_if.sink   item,
    shdr_out_if.source result
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_DEC
    } state_t;

    state_t                                 state_reg, state_next;
    logic [shdr_pkg::CLEAR_BITS-1:0]        clr_reg, clr_next;
    logic [shdr_pkg::SELECTOR_BITS-1:0]     sel_reg, sel_next;
    logic [shdr_pkg::LFSR_BITS-1:0]         lfsr_reg, lfsr_next;
    logic                                   out_valid_reg, out_valid_next;
    logic [shdr_pkg::VICTIM_W-1:0]          victim_reg, victim_next;
    logic [shdr_pkg::INSERTED_W-1:0]        inserted_reg, inserted_next;
    logic [shdr_pkg::SEL_OUT_W-1:0]         selector_reg, selector_next;

    logic [shdr_pkg::RRPV_BITS-1:0]         ins_reg, ins_next;
    logic [shdr_pkg::SIG_BITS-1:0]          old_sig_reg, old_sig_next;

    shdr_pkg::upd_op_t                      op_reg;
    logic [shdr_pkg::SET_BITS-1:0]          set_reg;
    logic [shdr_pkg::WAY_BITS-1:0]          way_reg;
    logic [shdr_pkg::SIG_BITS-1:0]          sig_reg;

    logic                                   accept;
    logic                                   slot_free;
    shdr_pkg::upd_op_t                      op_in;
    logic [shdr_pkg::SIG_BITS-1:0]          sig_in;

    logic                                   rr_we, sg_we, ct_we, ct_re;
    logic [shdr_pkg::SET_BITS-1:0]          rr_waddr, sg_waddr;
    logic [shdr_pkg::RR_ROW_BITS-1:0]       rr_wdata, rr_rdata;
    logic [shdr_pkg::SIG_ROW_BITS-1:0]      sg_wdata, sg_rdata;
    logic [shdr_pkg::SIG_BITS-1:0]          ct_waddr, ct_raddr;
    logic [shdr_pkg::CNT_BITS-1:0]          ct_wdata, cnt_rd, cnt_inc;

    shdr_pkg::role_t                        role;
    logic                                   bimodal_pick;
    logic [shdr_pkg::LFSR_BITS-1:0]         lfsr_step;
    logic [shdr_pkg::RRPV_BITS-1:0]         ins_fill;
    logic [shdr_pkg::RRPV_BITS-1:0]         new_rrpv;
    logic [shdr_pkg::SELECTOR_BITS-1:0]     sel_fill;
    shdr_pkg::row_upd_t                     upd;

    assign item.ready            = (state_reg == S_IDLE);
    assign accept                = item.valid && item.ready;
    assign slot_free             = !out_valid_reg || result.ready;
    assign result.valid          = out_valid_reg;
    assign result.victim_way     = victim_reg;
    assign result.inserted_value = inserted_reg;
    assign result.selector_value = selector_reg;

    assign sig_in = shdr_pkg::SIG_BITS'(item.pc_bits ^ item.line_bits);

    always_comb
    begin
        if (item.kind == shdr_pkg::KIND_FIND)
            op_in = shdr_pkg::UPD_FIND;
        else if (int'(item.way_index) >= shdr_pkg::WAYS)
            op_in = shdr_pkg::UPD_NOP;
        else if (item.is_hit == shdr_pkg::ACC_HIT)
            op_in = shdr_pkg::UPD_HIT;
        else
            op_in = shdr_pkg::UPD_FILL;
    end

    // Fill policy: set dueling, bimodal draw, then the strong-signature override.
    assign role         = shdr_pkg::set_role(set_reg);
    assign bimodal_pick = (role == shdr_pkg::ROLE_BIMODAL) ||
                          ((role == shdr_pkg::ROLE_FOLLOW) &&
                           !sel_reg[shdr_pkg::SELECTOR_BITS-1]);
    assign lfsr_step    = {lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5],
                           lfsr_reg[shdr_pkg::LFSR_BITS-1:1]};

    always_comb
    begin
        if (bimodal_pick && (lfsr_step[4:0] != 5'd0))
            ins_fill = shdr_pkg::RRPV_DISTANT;
        else
            ins_fill = shdr_pkg::RRPV_LONG;
        if (cnt_rd >= shdr_pkg::CNT_STRONG)
            ins_fill = shdr_pkg::RRPV_NEAR;
    end

    always_comb
    begin
        sel_fill = sel_reg;
        if ((role == shdr_pkg::ROLE_SRRIP) && (sel_reg != '0))
            sel_fill = sel_reg - 1'b1;
        else if ((role == shdr_pkg::ROLE_BIMODAL) && (sel_reg != shdr_pkg::SEL_MAX))
            sel_fill = sel_reg + 1'b1;
    end

    assign new_rrpv = (op_reg == shdr_pkg::UPD_FILL) ? ins_fill : shdr_pkg::RRPV_NEAR;
    assign cnt_inc  = (cnt_rd == shdr_pkg::CNT_MAX) ? cnt_rd : cnt_rd + 1'b1;

    shdr_row_update u_row (
        .op       (op_reg),
        .way      (way_reg),
        .new_rrpv (new_rrpv),
        .sig      (sig_reg),
        .rr_row   (rr_rdata),
        .sig_row  (sg_rdata),
        .upd      (upd)
    );

    shdr_ram #(
        .DEPTH (shdr_pkg::SETS),
        .WIDTH (shdr_pkg::RR_ROW_BITS)
    ) u_rr_ram (
        .clk   (clk),
        .we    (rr_we),
        .waddr (rr_waddr),
        .wdata (rr_wdata),
        .re    (accept),
        .raddr (shdr_pkg::SET_BITS'(item.set_index)),
        .rdata (rr_rdata)
    );

    shdr_ram #(
        .DEPTH (shdr_pkg::SETS),
        .WIDTH (shdr_pkg::SIG_ROW_BITS)
    ) u_sig_ram (
        .clk   (clk),
        .we    (sg_we),
        .waddr (sg_waddr),
        .wdata (sg_wdata),
        .re    (accept),
        .raddr (shdr_pkg::SET_BITS'(item.set_index)),
        .rdata (sg_rdata)
    );

    shdr_ram #(
        .DEPTH (shdr_pkg::SIG_COUNT),
        .WIDTH (shdr_pkg::CNT_BITS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (ct_we),
        .waddr (ct_waddr),
        .wdata (ct_wdata),
        .re    (ct_re),
        .raddr (ct_raddr),
        .rdata (cnt_rd)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        sel_next       = sel_reg;
        lfsr_next      = lfsr_reg;
        ins_next       = ins_reg;
        old_sig_next   = old_sig_reg;
        out_valid_next = out_valid_reg && !result.ready;
        victim_next    = victim_reg;
        inserted_next  = inserted_reg;
        selector_next  = selector_reg;

        rr_we    = 1'b0;
        rr_waddr = set_reg;
        rr_wdata = upd.rr_row;
        sg_we    = 1'b0;
        sg_waddr = set_reg;
        sg_wdata = upd.sig_row;
        ct_we    = 1'b0;
        ct_waddr = sig_reg;
        ct_wdata = cnt_inc;
        ct_re    = accept;
        ct_raddr = sig_in;

        case (state_reg)
            S_CLEAR:
            begin
                if (int'(clr_reg) < shdr_pkg::SETS)
                begin
                    rr_we    = 1'b1;
                    rr_waddr = clr_reg[shdr_pkg::SET_BITS-1:0];
                    rr_wdata = '1;
                    sg_we    = 1'b1;
                    sg_waddr = clr_reg[shdr_pkg::SET_BITS-1:0];
                    sg_wdata = '0;
                end
                if (int'(clr_reg) < shdr_pkg::SIG_COUNT)
                begin
                    ct_we    = 1'b1;
                    ct_waddr = clr_reg[shdr_pkg::SIG_BITS-1:0];
                    ct_wdata = '0;
                end
                if (clr_reg == shdr_pkg::CLEAR_BITS'(shdr_pkg::CLEAR_LEN - 1))
                    state_next = S_IDLE;
                clr_next = clr_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (accept)
                    state_next = S_MOD;
            end
            S_MOD:
            begin
                if (op_reg == shdr_pkg::UPD_FILL)
                begin
                    // Row write-back now; the replaced signature addresses the
                    // counter read for the next step.
                    rr_we        = 1'b1;
                    sg_we        = 1'b1;
                    ct_re        = 1'b1;
                    ct_raddr     = upd.old_sig;
                    if (bimodal_pick)
                        lfsr_next = lfsr_step;
                    sel_next     = sel_fill;
                    ins_next     = ins_fill;
                    old_sig_next = upd.old_sig;
                    state_next   = S_DEC;
                end
                else if (slot_free)
                begin
                    case (op_reg)
                        shdr_pkg::UPD_FIND:
                        begin
                            rr_we = 1'b1;
                        end
                        shdr_pkg::UPD_HIT:
                        begin
                            rr_we = 1'b1;
                            sg_we = 1'b1;
                            ct_we = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                    out_valid_next = 1'b1;
                    victim_next    = (op_reg == shdr_pkg::UPD_FIND) ?
                                     shdr_pkg::VICTIM_W'(upd.victim) : '0;
                    inserted_next  = '0;
                    selector_next  = shdr_pkg::SEL_OUT_W'(sel_reg);
                    state_next     = S_IDLE;
                end
            end
            S_DEC:
            begin
                if (slot_free)
                begin
                    if ((ins_reg != shdr_pkg::RRPV_NEAR) && (cnt_rd != '0))
                    begin
                        ct_we    = 1'b1;
                        ct_waddr = old_sig_reg;
                        ct_wdata = cnt_rd - 1'b1;
                    end
                    out_valid_next = 1'b1;
                    victim_next    = '0;
                    inserted_next  = shdr_pkg::INSERTED_W'(ins_reg);
                    selector_next  = shdr_pkg::SEL_OUT_W'(sel_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            sel_reg       <= shdr_pkg::SEL_MID;
            lfsr_reg      <= shdr_pkg::LFSR_SEED;
            out_valid_reg <= 1'b0;
            victim_reg    <= '0;
            inserted_reg  <= '0;
            selector_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            sel_reg       <= sel_next;
            lfsr_reg      <= lfsr_next;
            out_valid_reg <= out_valid_next;
            victim_reg    <= victim_next;
            inserted_reg  <= inserted_next;
            selector_reg  <= selector_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ins_reg     <= ins_next;
        old_sig_reg <= old_sig_next;
        if (accept)
        begin
            op_reg  <= op_in;
            set_reg <= shdr_pkg::SET_BITS'(item.set_index);
            way_reg <= shdr_pkg::WAY_BITS'(item.way_index);
            sig_reg <= sig_in;
        end
    end

endmodule

`default_nettype wire

// ----- design/shdr_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module shdr_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/shdr_row_update.sv -----
// Set-row modify logic: aging and victim search for finds, way insertion for
// hits and fills, and extraction of the replaced block's signature. Uses shdr_pkg.
`default_nettype none

module shdr_row_update (
    input  wire shdr_pkg::upd_op_t                 op,
    input  wire logic [shdr_pkg::WAY_BITS-1:0]     way,
    input  wire logic [shdr_pkg::RRPV_BITS-1:0]    new_rrpv,
    input  wire logic [shdr_pkg::SIG_BITS-1:0]     sig,
    input  wire logic [shdr_pkg::RR_ROW_BITS-1:0]  rr_row,
    input  wire logic [shdr_pkg::SIG_ROW_BITS-1:0] sig_row,
    output      shdr_pkg::row_upd_t                upd
);

    always_comb
    begin
        logic                               any_top;
        logic                               any_hi;
        logic                               any_lo;
        logic [shdr_pkg::RRPV_BITS-1:0]     v;
        logic [shdr_pkg::RRPV_BITS-1:0]     mx;
        logic [shdr_pkg::RRPV_BITS-1:0]     add;
        logic [shdr_pkg::RR_ROW_BITS-1:0]   aged;
        logic [shdr_pkg::RR_ROW_BITS-1:0]   rr_ins;
        logic [shdr_pkg::SIG_ROW_BITS-1:0]  sig_ins;

        any_top = 1'b0;
        any_hi  = 1'b0;
        any_lo  = 1'b0;
        for (int w = 0; w < shdr_pkg::WAYS; w++)
        begin
            v       = rr_row[w*shdr_pkg::RRPV_BITS +: shdr_pkg::RRPV_BITS];
            any_top = any_top | (&v);
            any_hi  = any_hi | v[1];
            any_lo  = any_lo | v[0];
        end

        // The set maximum follows from three independent reductions.
        if (any_top)
            mx = 2'd3;
        else if (any_hi)
            mx = 2'd2;
        else if (any_lo)
            mx = 2'd1;
        else
            mx = 2'd0;
        add = shdr_pkg::RRPV_DISTANT - mx;

        for (int w = 0; w < shdr_pkg::WAYS; w++)
        begin
            aged[w*shdr_pkg::RRPV_BITS +: shdr_pkg::RRPV_BITS] =
                rr_row[w*shdr_pkg::RRPV_BITS +: shdr_pkg::RRPV_BITS] + add;
        end

        // Scan downward so that the lowest distant way is the one kept.
        upd.victim = '0;
        for (int w = shdr_pkg::WAYS - 1; w >= 0; w--)
        begin
            if (aged[w*shdr_pkg::RRPV_BITS +: shdr_pkg::RRPV_BITS] == shdr_pkg::RRPV_DISTANT)
            begin
                upd.victim = shdr_pkg::WAY_BITS'(w);
            end
        end

        upd.old_sig = sig_row[way*shdr_pkg::SIG_BITS +: shdr_pkg::SIG_BITS];

        rr_ins  = rr_row;
        sig_ins = sig_row;
        rr_ins[way*shdr_pkg::RRPV_BITS +: shdr_pkg::RRPV_BITS] = new_rrpv;
        sig_ins[way*shdr_pkg::SIG_BITS +: shdr_pkg::SIG_BITS]  = sig;

        case (op)
            shdr_pkg::UPD_FIND:
            begin
                upd.rr_row  = aged;
                upd.sig_row = sig_row;
            end
            shdr_pkg::UPD_HIT, shdr_pkg::UPD_FILL:
            begin
                upd.rr_row  = rr_ins;
                upd.sig_row = sig_ins;
            end
            default:
            begin
                upd.rr_row  = rr_row;
                upd.sig_row = sig_row;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- verif/ship_drrip_cache_replacement_top_tb.sv -----
// Testbench for ship_drrip_cache_replacement_top: drives request words, predicts every
// result word with a behavioral copy of the replacement state, and checks them in order.
// Depends on design/shdr_pkg.sv, design/shdr_if.sv and the RTL of the block.
`default_nettype none

module ship_drrip_cache_replacement_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEADER_GAP = shdr_pkg::SETS / shdr_pkg::LEADER_SETS;

    typedef struct packed {
        logic [shdr_pkg::KIND_W-1:0]    kind;
        logic [shdr_pkg::SET_IDX_W-1:0] set_index;
        logic [shdr_pkg::WAY_IDX_W-1:0] way_index;
        logic [shdr_pkg::PC_W-1:0]      pc_bits;
        logic [shdr_pkg::LINE_W-1:0]    line_bits;
        logic [shdr_pkg::HIT_W-1:0]     is_hit;
    } req_word_t;

    typedef struct packed {
        logic [shdr_pkg::VICTIM_W-1:0]   victim_way;
        logic [shdr_pkg::INSERTED_W-1:0] inserted_value;
        logic [shdr_pkg::SEL_OUT_W-1:0]  selector_value;
    } rsp_word_t;

    logic clk;
    logic rst_n;

    shdr_in_if  item_ch ();
    shdr_out_if result_ch ();

    ship_drrip_cache_replacement_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // Predicted replacement state.
    logic [shdr_pkg::RRPV_BITS-1:0]     rrpv_mem [shdr_pkg::SETS][shdr_pkg::WAYS];
    logic [shdr_pkg::SIG_BITS-1:0]      sig_mem [shdr_pkg::SETS][shdr_pkg::WAYS];
    logic [shdr_pkg::CNT_BITS-1:0]      reuse_cnt [shdr_pkg::SIG_COUNT];
    logic [shdr_pkg::SELECTOR_BITS-1:0] duel_sel;
    logic [shdr_pkg::LFSR_BITS-1:0]     lfsr_state;

    rsp_word_t       expected_rsp_q [$];
    int              mismatches = 0;
    int              src_idle_pct = 0;
    int              sink_stall_pct = 0;
    shdr_pkg::role_t fill_lean = shdr_pkg::ROLE_FOLLOW;
    int unsigned     hot_sets [8] = '{0, 64, 32, 2016, 1, 1234, 2047, 1984};
    int unsigned     sig_pool [4] = '{0, 5, 42, 63};

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic shdr_pkg::role_t leader_role(input int unsigned set_i);
        shdr_pkg::role_t role;
        role = shdr_pkg::ROLE_FOLLOW;
        if (set_i % LEADER_GAP == 0)
        begin
            role = ((set_i / LEADER_GAP) % 2 == 1) ? shdr_pkg::ROLE_BIMODAL
                                                   : shdr_pkg::ROLE_SRRIP;
        end
        return role;
    endfunction

    // Applies one request word to the predicted state and returns its result word.
    function automatic rsp_word_t predict_replacement(input req_word_t w);
        int unsigned                    set_i;
        int unsigned                    way_i;
        int                             i;
        logic [shdr_pkg::SIG_BITS-1:0]  new_sig;
        logic [shdr_pkg::SIG_BITS-1:0]  old_sig;
        logic [shdr_pkg::RRPV_BITS-1:0] top;
        logic [shdr_pkg::RRPV_BITS-1:0] ins;
        logic                           fb;
        shdr_pkg::role_t                role;
        rsp_word_t                      r;
        set_i      = w.set_index % shdr_pkg::SETS;
        way_i      = 32'(w.way_index);
        new_sig    = w.pc_bits ^ w.line_bits;
        ins        = shdr_pkg::RRPV_NEAR;
        r          = '0;
        if (w.kind == shdr_pkg::KIND_FIND)
        begin
            top = '0;
            for (i = 0; i < shdr_pkg::WAYS; i++)
            begin
                if (rrpv_mem[set_i][i] > top)
                    top = rrpv_mem[set_i][i];
            end
            // No distant block: age the whole set until the oldest one reaches distant.
            if (top != shdr_pkg::RRPV_DISTANT)
            begin
                for (i = 0; i < shdr_pkg::WAYS; i++)
                    rrpv_mem[set_i][i] = rrpv_mem[set_i][i] + (shdr_pkg::RRPV_DISTANT - top);
            end
            for (i = shdr_pkg::WAYS - 1; i >= 0; i--)
            begin
                if (rrpv_mem[set_i][i] == shdr_pkg::RRPV_DISTANT)
                    r.victim_way = shdr_pkg::VICTIM_W'(i);
            end
        end
        else if (way_i < shdr_pkg::WAYS)
        begin
            if (w.is_hit == shdr_pkg::ACC_HIT)
            begin
                sig_mem[set_i][way_i] = new_sig;
                if (reuse_cnt[new_sig] != shdr_pkg::CNT_MAX)
                    reuse_cnt[new_sig] = reuse_cnt[new_sig] + 1'b1;
                rrpv_mem[set_i][way_i] = shdr_pkg::RRPV_NEAR;
            end
            else
            begin
                role    = leader_role(set_i);
                old_sig = sig_mem[set_i][way_i];
                if (role == shdr_pkg::ROLE_SRRIP)
                    ins = shdr_pkg::RRPV_LONG;
                else if (role == shdr_pkg::ROLE_BIMODAL || duel_sel < shdr_pkg::SEL_MID)
                begin
                    fb         = lfsr_state[0] ^ lfsr_state[2] ^ lfsr_state[3] ^
                                 lfsr_state[5];
                    lfsr_state = {fb, lfsr_state[shdr_pkg::LFSR_BITS-1:1]};
                    ins        = (lfsr_state[4:0] == '0) ? shdr_pkg::RRPV_LONG
                                                         : shdr_pkg::RRPV_DISTANT;
                end
                else
                    ins = shdr_pkg::RRPV_LONG;
                if (reuse_cnt[new_sig] >= shdr_pkg::CNT_STRONG)
                    ins = shdr_pkg::RRPV_NEAR;
                rrpv_mem[set_i][way_i] = ins;
                sig_mem[set_i][way_i]  = new_sig;
                if (ins != shdr_pkg::RRPV_NEAR && reuse_cnt[old_sig] != '0)
                    reuse_cnt[old_sig] = reuse_cnt[old_sig] - 1'b1;
                if (role == shdr_pkg::ROLE_SRRIP && duel_sel != '0)
                    duel_sel = duel_sel - 1'b1;
                else if (role == shdr_pkg::ROLE_BIMODAL && duel_sel != shdr_pkg::SEL_MAX)
                    duel_sel = duel_sel + 1'b1;
            end
        end
        r.inserted_value = ins;
        r.selector_value = duel_sel;
        return r;
    endfunction

    task automatic clear_prediction();
        int s;
        int w;
        for (s = 0; s < shdr_pkg::SETS; s++)
        begin
            for (w = 0; w < shdr_pkg::WAYS; w++)
            begin
                rrpv_mem[s][w] = shdr_pkg::RRPV_DISTANT;
                sig_mem[s][w]  = '0;
            end
        end
        for (s = 0; s < shdr_pkg::SIG_COUNT; s++)
            reuse_cnt[s] = '0;
        duel_sel   = shdr_pkg::SEL_MID;
        lfsr_state = shdr_pkg::LFSR_SEED;
    endtask

    // Offers one word after a random idle gap and waits until it is taken.
    task automatic send_word(input req_word_t w);
        int gap;
        gap = 0;
        while (gap < 12 && $urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.kind      <= w.kind;
        item_ch.set_index <= w.set_index;
        item_ch.way_index <= w.way_index;
        item_ch.pc_bits   <= w.pc_bits;
        item_ch.line_bits <= w.line_bits;
        item_ch.is_hit    <= w.is_hit;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        expected_rsp_q.push_back(predict_replacement(w));
    endtask

    task automatic send_fields(input logic [shdr_pkg::KIND_W-1:0] kind,
                               input int unsigned set_i,
                               input int unsigned way_i, input int unsigned pc,
                               input int unsigned line,
                               input logic [shdr_pkg::HIT_W-1:0] hit);
        req_word_t w;
        w.kind      = kind;
        w.set_index = shdr_pkg::SET_IDX_W'(set_i);
        w.way_index = shdr_pkg::WAY_IDX_W'(way_i);
        w.pc_bits   = shdr_pkg::PC_W'(pc);
        w.line_bits = shdr_pkg::LINE_W'(line);
        w.is_hit    = hit;
        send_word(w);
    endtask

    function automatic req_word_t random_word();
        req_word_t   w;
        int unsigned pick;
        pick        = $urandom_range(99);
        w.kind      = (pick < 30) ? shdr_pkg::KIND_FIND : shdr_pkg::KIND_UPDATE;
        w.is_hit    = (pick < 30) ? shdr_pkg::HIT_W'($urandom_range(1)) :
                      ((pick < 60) ? shdr_pkg::ACC_HIT : shdr_pkg::ACC_FILL);
        w.set_index = ($urandom_range(9) == 0) ?
                      shdr_pkg::SET_IDX_W'($urandom_range(shdr_pkg::SETS - 1)) :
                      shdr_pkg::SET_IDX_W'(hot_sets[$urandom_range(7)]);
        // Fills lean toward one kind of leader set to push the selector one way.
        if (w.kind == shdr_pkg::KIND_UPDATE && w.is_hit == shdr_pkg::ACC_FILL &&
            $urandom_range(1) == 1)
        begin
            if (fill_lean == shdr_pkg::ROLE_SRRIP)
                w.set_index = shdr_pkg::SET_IDX_W'($urandom_range(2) * 64 +
                              (($urandom_range(1) == 1) ? 1920 : 0));
            else if (fill_lean == shdr_pkg::ROLE_BIMODAL)
                w.set_index = ($urandom_range(1) == 1) ? shdr_pkg::SET_IDX_W'(32)
                                                        : shdr_pkg::SET_IDX_W'(2016);
        end
        w.way_index = shdr_pkg::WAY_IDX_W'($urandom_range(shdr_pkg::WAYS - 1));
        w.pc_bits   = shdr_pkg::PC_W'($urandom_range(63));
        w.line_bits = ($urandom_range(9) < 7) ?
                      shdr_pkg::LINE_W'(w.pc_bits ^ sig_pool[$urandom_range(3)]) :
                      shdr_pkg::LINE_W'($urandom_range(63));
        return w;
    endfunction

    task automatic test_extremes();
        send_fields(shdr_pkg::KIND_FIND, 0, 0, 0, 0, shdr_pkg::ACC_FILL);
        send_fields(shdr_pkg::KIND_UPDATE, 0, 15, 63, 63, shdr_pkg::ACC_FILL);
        send_fields(shdr_pkg::KIND_UPDATE, 32, 0, 0, 0, shdr_pkg::ACC_FILL);
        send_fields(shdr_pkg::KIND_UPDATE, 2047, 7, 21, 42, shdr_pkg::ACC_FILL);
        send_fields(shdr_pkg::KIND_FIND, 2047, 15, 63, 0, shdr_pkg::ACC_HIT);
    endtask

    // Every way of one set is hit, so the next find must age the set.
    task automatic test_aging();
        int w;
        for (w = 0; w < shdr_pkg::WAYS; w++)
            send_fields(shdr_pkg::KIND_UPDATE, 1234, w, w * 4, (w * 4) ^ 42,
                        shdr_pkg::ACC_HIT);
        send_fields(shdr_pkg::KIND_FIND, 1234, 0, 0, 0, shdr_pkg::ACC_FILL);
    endtask

    // The signature used above is now saturated: a fill with it goes in near, and a
    // weak fill over one of its blocks weakens it again.
    task automatic test_signature_strength();
        send_fields(shdr_pkg::KIND_UPDATE, 1234, 3, 63, 63 ^ 42, shdr_pkg::ACC_FILL);
        send_fields(shdr_pkg::KIND_UPDATE, 1234, 5, 0, 1, shdr_pkg::ACC_FILL);
        send_fields(shdr_pkg::KIND_FIND, 1234, 9, 17, 33, shdr_pkg::ACC_HIT);
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                    input shdr_pkg::role_t lean, input int count);
        int          sent;
        int          w;
        int unsigned set_i;
        int unsigned pc;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        fill_lean      = lean;
        sent           = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 4)
            begin
                set_i = hot_sets[$urandom_range(7)];
                for (w = 0; w < shdr_pkg::WAYS; w++)
                begin
                    pc = $urandom_range(63);
                    send_fields(shdr_pkg::KIND_UPDATE, set_i, w, pc,
                                pc ^ sig_pool[$urandom_range(3)], shdr_pkg::ACC_HIT);
                end
                send_fields(shdr_pkg::KIND_FIND, set_i, $urandom_range(15),
                            $urandom_range(63), $urandom_range(63),
                            shdr_pkg::HIT_W'($urandom_range(1)));
                sent += shdr_pkg::WAYS + 1;
            end
            else
            begin
                send_word(random_word());
                sent++;
            end
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, shdr_pkg::ROLE_SRRIP, 185);
        run_random_phase(45, 0, shdr_pkg::ROLE_SRRIP, 185);
        run_random_phase(0, 45, shdr_pkg::ROLE_BIMODAL, 185);
        run_random_phase(20, 20, shdr_pkg::ROLE_FOLLOW, 185);
    endtask

    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic report_field(input string name, input int unsigned exp_v,
                                input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        rsp_word_t exp_w;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                $display("%0t: unexpected result word: expected none, actual %0d/%0d/%0d",
                         $time, result_ch.victim_way, result_ch.inserted_value,
                         result_ch.selector_value);
                mismatches++;
            end
            else
            begin
                exp_w = expected_rsp_q.pop_front();
                report_field("victim_way", exp_w.victim_way, result_ch.victim_way);
                report_field("inserted_value", exp_w.inserted_value, result_ch.inserted_value);
                report_field("selector_value", exp_w.selector_value, result_ch.selector_value);
            end
        end
    end

    initial
    begin
        rst_n             <= 1'b0;
        item_ch.valid     <= 1'b0;
        item_ch.kind      <= shdr_pkg::KIND_FIND;
        item_ch.set_index <= '0;
        item_ch.way_index <= '0;
        item_ch.pc_bits   <= '0;
        item_ch.line_bits <= '0;
        item_ch.is_hit    <= shdr_pkg::ACC_FILL;
        clear_prediction();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_extremes();
        test_aging();
        test_signature_strength();
        test_random_traffic();
        item_ch.valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("ship_drrip_cache_replacement_top verification clean");
        else
            $display("ship_drrip_cache_replacement_top verification failed");
        $finish;
    end

    // Clearing pass plus every word at its slowest handshake fits well inside this.
    initial
    begin
        #10ms;
        $display("ship_drrip_cache_replacement_top verification failed");
        $finish;
    end

endmodule

`default_nettype wire
